// File: design/stftvw_pkg.sv
package stftvw_pkg;

    localparam int FRAME_SIZE = 960;
    localparam int HOP_LEN    = 480;

    localparam int SAMPLE_W = 16;
    localparam int BIN_W    = 9;
    localparam int OUT_W    = 27;
    localparam int COEF_W   = 16;
    localparam int TW_W     = 2 * COEF_W;
    localparam int OPB_W    = COEF_W + 1;
    localparam int PROD_W   = SAMPLE_W + OPB_W;
    localparam int RND_SH   = 15;
    localparam int RND_HALF = 1 << (RND_SH - 1);

    localparam int ADDR_W = $clog2(FRAME_SIZE);
    localparam int FILL_W = $clog2(FRAME_SIZE + 1);
    localparam int POS_W  = $clog2(HOP_LEN);
    localparam int ACC_W  = (PROD_W + ADDR_W > RND_SH + OUT_W) ?
                            (PROD_W + ADDR_W) : (RND_SH + OUT_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DFT_RUN,
        ST_DFT_WAIT,
        ST_PUBLISH,
        ST_FRZ_RUN,
        ST_FRZ_WAIT
    } seq_state_t;

    localparam longint PI_HALF_Q30   = 64'sd1686629713;
    localparam longint WIN_PHASE_DEN = longint'(4 * FRAME_SIZE);
    localparam longint TW_PHASE_DEN  = longint'(FRAME_SIZE);

    // sine of a q32 fraction of a turn, q30 result, taylor series to x^13
    function automatic longint sin_q30(input logic [31:0] phase);
        longint r;
        longint x;
        longint x2;
        longint term;
        longint sum;
        r = longint'({34'd0, phase[29:0]});
        x = (r * PI_HALF_Q30) >>> 30;
        if (phase[30])
        begin
            x = PI_HALF_Q30 - x;
        end
        x2 = (x * x) >>> 30;
        term = x;
        sum = x;
        term = ((term * x2) >>> 30) / 64'sd6;
        sum = sum - term;
        term = ((term * x2) >>> 30) / 64'sd20;
        sum = sum + term;
        term = ((term * x2) >>> 30) / 64'sd42;
        sum = sum - term;
        term = ((term * x2) >>> 30) / 64'sd72;
        sum = sum + term;
        term = ((term * x2) >>> 30) / 64'sd110;
        sum = sum - term;
        term = ((term * x2) >>> 30) / 64'sd156;
        sum = sum + term;
        if (phase[31])
        begin
            sum = -sum;
        end
        return sum;
    endfunction

    function automatic longint q30_to_q15(input longint v, input longint lo);
        longint q;
        q = (v + 64'sd16384) >>> 15;
        if (q > 64'sd32767)
        begin
            q = 64'sd32767;
        end
        if (q < lo)
        begin
            q = lo;
        end
        return q;
    endfunction

    function automatic logic [FRAME_SIZE*COEF_W-1:0] build_window_rom();
        logic [FRAME_SIZE*COEF_W-1:0] rom;
        longint num;
        longint inner;
        logic [63:0] sq;
        logic [31:0] ph1;
        rom = '0;
        for (int i = 0; i < FRAME_SIZE; i++)
        begin
            num = longint'(2 * i + 1) <<< 32;
            ph1 = 32'(num / WIN_PHASE_DEN);
            inner = sin_q30(ph1);
            sq = 64'(inner * inner);
            rom[i*COEF_W +: COEF_W] = COEF_W'(q30_to_q15(sin_q30(sq[61:30]), 64'sd0));
        end
        return rom;
    endfunction

    // bits 31..16 cosine, bits 15..0 negated sine
    function automatic logic [FRAME_SIZE*TW_W-1:0] build_twiddle_rom();
        logic [FRAME_SIZE*TW_W-1:0] rom;
        logic [31:0] ph;
        logic [31:0] phc;
        longint c;
        longint s;
        rom = '0;
        for (int i = 0; i < FRAME_SIZE; i++)
        begin
            ph = 32'((longint'(i) <<< 32) / TW_PHASE_DEN);
            phc = ph + 32'h4000_0000;
            c = q30_to_q15(sin_q30(phc), -64'sd32768);
            s = q30_to_q15(-sin_q30(ph), -64'sd32768);
            rom[i*TW_W +: TW_W] = {COEF_W'(c), COEF_W'(s)};
        end
        return rom;
    endfunction

    localparam logic [FRAME_SIZE*COEF_W-1:0] WINDOW_ROM  = build_window_rom();
    localparam logic [FRAME_SIZE*TW_W-1:0]   TWIDDLE_ROM = build_twiddle_rom();

endpackage

// File: design/stft_analysis_vorbis_window.sv
// Short-time spectrum analyzer: every accepted sample request enters a frame history, and
// each sample returns one bin of the most recent windowed frame as a direct DFT. A request
// with spectrum data makes one multiply-accumulate pass over the frozen frame and twiddle
// rom before the next acceptance; its result is registered as the input frees up, or just
// before a window pass. A request without spectrum data goes straight to the result
// register. The request that completes a hop adds a window pass through the same
// multiplier before the next request is taken. The input stalls while a request is in
// work; a finished result waits in the output register and only holds up the next request
// once that one's result is also ready. Before the first completed hop the result carries
// spectrum_valid low and all other fields zero. No clearing pass follows reset.
module stft_analysis_vorbis_window (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic signed [stftvw_pkg::SAMPLE_W-1:0] sample,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [stftvw_pkg::BIN_W-1:0]         bin_index,
    output logic signed [stftvw_pkg::OUT_W-1:0]  bin_real,
    output logic signed [stftvw_pkg::OUT_W-1:0]  bin_imag,
    output logic                                 spectrum_valid,
    output logic                                 last_bin
);
    import stftvw_pkg::*;

    seq_state_t state_reg;
    seq_state_t state_next;

    logic signed [SAMPLE_W-1:0] hist_mem [FRAME_SIZE];
    logic signed [SAMPLE_W-1:0] frz_mem [FRAME_SIZE];

    logic [ADDR_W-1:0] wr_ptr_reg;
    logic [ADDR_W-1:0] wr_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [POS_W-1:0]  hop_pos_reg;
    logic [POS_W-1:0]  bin_pos_reg;
    logic              frame_seen_reg;
    logic              has_spec_reg;
    logic              freeze_pend_reg;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] tw_idx_reg;
    logic [ADDR_W-1:0] tw_idx_next;
    logic [ADDR_W-1:0] hist_addr;
    logic [ADDR_W:0]   tw_sum;
    logic [ADDR_W:0]   hist_sum;
    logic [FILL_W:0]   live_sum;
    logic              live;

    logic accept;
    logic issue;
    logic last_issue;
    logic pipe_empty;
    logic out_free;
    logic publish;
    logic frz_mode;

    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic              live_s1_reg;
    logic [ADDR_W-1:0] cnt_s1_reg;
    logic [ADDR_W-1:0] cnt_s2_reg;

    logic signed [SAMPLE_W-1:0] hist_rd_reg;
    logic signed [SAMPLE_W-1:0] frz_rd_reg;
    logic [COEF_W-1:0]          win_rd_reg;
    logic [TW_W-1:0]            tw_rd_reg;

    logic signed [SAMPLE_W-1:0] opa_re;
    logic signed [OPB_W-1:0]    opb_re;
    logic signed [OPB_W-1:0]    opb_im;
    logic signed [PROD_W-1:0]   prod_re_reg;
    logic signed [PROD_W-1:0]   prod_im_reg;
    logic signed [PROD_W-1:0]   frz_rnd;
    logic signed [ACC_W-1:0]    acc_re_reg;
    logic signed [ACC_W-1:0]    acc_im_reg;
    logic signed [ACC_W-1:0]    rnd_re;
    logic signed [ACC_W-1:0]    rnd_im;

    logic                    out_valid_reg;
    logic [BIN_W-1:0]        bin_index_reg;
    logic signed [OUT_W-1:0] bin_real_reg;
    logic signed [OUT_W-1:0] bin_imag_reg;
    logic                    spectrum_valid_reg;
    logic                    last_bin_reg;

    // sequencer outputs
    always_comb
    begin
        accept     = (state_reg == ST_IDLE) && sample_valid;
        issue      = (state_reg == ST_DFT_RUN) || (state_reg == ST_FRZ_RUN);
        last_issue = issue && (cnt_reg == ADDR_W'(FRAME_SIZE - 1));
        pipe_empty = !s1_valid_reg && !s2_valid_reg;
        out_free   = !out_valid_reg || !result_stall;
        publish    = (state_reg == ST_PUBLISH) && out_free;
        frz_mode   = (state_reg == ST_FRZ_RUN) || (state_reg == ST_FRZ_WAIT);
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = frame_seen_reg ? ST_DFT_RUN : ST_PUBLISH;
                end
            end
            ST_DFT_RUN:
            begin
                if (last_issue)
                begin
                    state_next = ST_DFT_WAIT;
                end
            end
            ST_DFT_WAIT:
            begin
                if (pipe_empty)
                begin
                    state_next = ST_PUBLISH;
                end
            end
            ST_PUBLISH:
            begin
                if (out_free)
                begin
                    state_next = freeze_pend_reg ? ST_FRZ_RUN : ST_IDLE;
                end
            end
            ST_FRZ_RUN:
            begin
                if (last_issue)
                begin
                    state_next = ST_FRZ_WAIT;
                end
            end
            ST_FRZ_WAIT:
            begin
                if (pipe_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // address arithmetic, all modulo the frame length
    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == ADDR_W'(FRAME_SIZE - 1)) ? '0 : wr_ptr_reg + 1'b1;

        tw_sum = {1'b0, tw_idx_reg} + (ADDR_W + 1)'(bin_pos_reg);
        if (tw_sum >= (ADDR_W + 1)'(FRAME_SIZE))
        begin
            tw_idx_next = ADDR_W'(tw_sum - (ADDR_W + 1)'(FRAME_SIZE));
        end
        else
        begin
            tw_idx_next = ADDR_W'(tw_sum);
        end

        // oldest history entry sits at the write pointer
        hist_sum = {1'b0, wr_ptr_reg} + {1'b0, cnt_reg};
        if (hist_sum >= (ADDR_W + 1)'(FRAME_SIZE))
        begin
            hist_addr = ADDR_W'(hist_sum - (ADDR_W + 1)'(FRAME_SIZE));
        end
        else
        begin
            hist_addr = ADDR_W'(hist_sum);
        end

        // entries older than the fill count read as zero
        live_sum = (FILL_W + 1)'(cnt_reg) + (FILL_W + 1)'(fill_reg);
        live = live_sum >= (FILL_W + 1)'(FRAME_SIZE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            wr_ptr_reg      <= '0;
            fill_reg        <= '0;
            hop_pos_reg     <= '0;
            bin_pos_reg     <= '0;
            frame_seen_reg  <= 1'b0;
            has_spec_reg    <= 1'b0;
            freeze_pend_reg <= 1'b0;
            cnt_reg         <= '0;
            tw_idx_reg      <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;

            if (accept)
            begin
                wr_ptr_reg   <= wr_ptr_next;
                bin_pos_reg  <= hop_pos_reg;
                has_spec_reg <= frame_seen_reg;
                tw_idx_reg   <= '0;
                if (fill_reg != FILL_W'(FRAME_SIZE))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                if (hop_pos_reg == POS_W'(HOP_LEN - 1))
                begin
                    hop_pos_reg     <= '0;
                    freeze_pend_reg <= 1'b1;
                    frame_seen_reg  <= 1'b1;
                end
                else
                begin
                    hop_pos_reg     <= hop_pos_reg + 1'b1;
                    freeze_pend_reg <= 1'b0;
                end
            end
            else if (state_reg == ST_DFT_RUN)
            begin
                tw_idx_reg <= tw_idx_next;
            end

            if (issue)
            begin
                cnt_reg <= last_issue ? '0 : cnt_reg + 1'b1;
            end

            if (publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // history and frozen frame memories
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_mem[wr_ptr_reg] <= sample;
        end
        hist_rd_reg <= hist_mem[hist_addr];
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && frz_mode)
        begin
            frz_mem[cnt_s2_reg] <= frz_rnd[RND_SH+SAMPLE_W-1:RND_SH];
        end
        frz_rd_reg <= frz_mem[cnt_reg];
    end

    // coefficient roms
    always_ff @(posedge clk)
    begin
        win_rd_reg <= WINDOW_ROM[cnt_reg*COEF_W +: COEF_W];
        tw_rd_reg  <= TWIDDLE_ROM[tw_idx_reg*TW_W +: TW_W];
    end

    // shared multiply unit: window products or cosine/sine products
    always_comb
    begin
        if (frz_mode)
        begin
            opa_re = live_s1_reg ? hist_rd_reg : '0;
            opb_re = signed'({1'b0, win_rd_reg});
        end
        else
        begin
            opa_re = frz_rd_reg;
            opb_re = signed'({tw_rd_reg[TW_W-1], tw_rd_reg[TW_W-1:COEF_W]});
        end
        opb_im  = signed'({tw_rd_reg[COEF_W-1], tw_rd_reg[COEF_W-1:0]});
        frz_rnd = prod_re_reg + PROD_W'(RND_HALF);
        rnd_re  = acc_re_reg + ACC_W'(RND_HALF);
        rnd_im  = acc_im_reg + ACC_W'(RND_HALF);
    end

    always_ff @(posedge clk)
    begin
        live_s1_reg <= live;
        cnt_s1_reg  <= cnt_reg;
        cnt_s2_reg  <= cnt_s1_reg;
        prod_re_reg <= opa_re * opb_re;
        prod_im_reg <= frz_rd_reg * opb_im;

        if (accept)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (s2_valid_reg && !frz_mode)
        begin
            acc_re_reg <= acc_re_reg + ACC_W'(prod_re_reg);
            acc_im_reg <= acc_im_reg + ACC_W'(prod_im_reg);
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (publish)
        begin
            if (has_spec_reg)
            begin
                bin_index_reg      <= BIN_W'(bin_pos_reg);
                bin_real_reg       <= rnd_re[RND_SH+OUT_W-1:RND_SH];
                bin_imag_reg       <= rnd_im[RND_SH+OUT_W-1:RND_SH];
                spectrum_valid_reg <= 1'b1;
                last_bin_reg       <= (bin_pos_reg == POS_W'(HOP_LEN - 1));
            end
            else
            begin
                bin_index_reg      <= '0;
                bin_real_reg       <= '0;
                bin_imag_reg       <= '0;
                spectrum_valid_reg <= 1'b0;
                last_bin_reg       <= 1'b0;
            end
        end
    end

    assign sample_stall   = (state_reg != ST_IDLE);
    assign result_valid   = out_valid_reg;
    assign bin_index      = bin_index_reg;
    assign bin_real       = bin_real_reg;
    assign bin_imag       = bin_imag_reg;
    assign spectrum_valid = spectrum_valid_reg;
    assign last_bin       = last_bin_reg;

endmodule
